@@ src/dfas_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfas_pkg: shared definitions for the multi-pattern DFA search block
// Request kinds, field widths, default sizes, the queue entry between the
// front and back parts, and the ASCII case fold.
// ----------------------------------------------------------------------------
package dfas_pkg;

	// Request kinds carried in s_tuser.
	localparam logic [1:0] REQ_SEARCH   = 2'd0;
	localparam logic [1:0] REQ_WR_TRANS = 2'd1;
	localparam logic [1:0] REQ_WR_MATCH = 2'd2;
	localparam logic [1:0] REQ_LOAD     = 2'd3;

	// Field widths.
	localparam int REQ_W     = 2;
	localparam int SYM_W     = 8;
	localparam int STATE_W   = 12;
	localparam int PAT_W     = 16;
	localparam int POS_OUT_W = 17;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	// Sizes.
	localparam int ALPHABET        = 256;
	localparam int MAX_ROWS        = 4096;
	localparam int NUM_STATES_DEF  = 4096;
	localparam int PAT_ID_BITS_DEF = 16;
	localparam int MAX_BUFFER_DEF  = 64 * 1024;
	localparam int Q_DEPTH         = 4;
	localparam int Q_PTR_W         = 2;
	localparam int Q_CNT_W         = 3;

	// One request as it travels from the front part to the back part.
	typedef struct packed {
		logic               is_search;
		logic               is_mwrite;
		logic               first;
		logic [STATE_W-1:0] state;
		logic [STATE_W-1:0] addr;
		logic               ematch;
		logic [PAT_W-1:0]   epat;
	} q_entry_t;

	// Folds ASCII lower case letters to upper case; other bytes pass.
	function automatic logic [SYM_W-1:0] fold_upper(input logic [SYM_W-1:0] c);
		logic [SYM_W-1:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/dfas_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfas_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and shows the
// old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
module dfas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ src/dfas_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfas_front: request intake and automaton stepping
// Accepts requests, writes the next-state table, steps the automaton one byte
// per cycle unless held, and passes on each request with its resulting state.
// ----------------------------------------------------------------------------
module dfas_front #(
	parameter int NUM_STATES = dfas_pkg::NUM_STATES_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire [dfas_pkg::IN_DATA_W-1:0]   s_tdata,
	input  wire [dfas_pkg::REQ_W-1:0]       s_tuser,
	input  wire [dfas_pkg::Q_CNT_W-1:0]     q_count,
	output logic                            push,
	output dfas_pkg::q_entry_t              push_entry
);
	import dfas_pkg::*;

	localparam int ROWS   = (NUM_STATES < MAX_ROWS) ? NUM_STATES : MAX_ROWS;
	localparam int RB     = $clog2(ROWS);
	localparam int TDEPTH = ROWS * ALPHABET;
	localparam int TAW    = $clog2(TDEPTH);

	logic [SYM_W-1:0]   symbol;
	logic               first_in_buffer;
	logic [STATE_W-1:0] state_addr;
	logic [STATE_W-1:0] target_state;
	logic               entry_matches;
	logic [PAT_W-1:0]   entry_pattern;

	assign symbol          = s_tdata[7:0];
	assign first_in_buffer = s_tdata[8];
	assign state_addr      = s_tdata[20:9];
	assign target_state    = s_tdata[32:21];
	assign entry_matches   = s_tdata[33];
	assign entry_pattern   = s_tdata[49:34];

	logic               accept;
	logic               fresh_q;
	logic               oor_q;
	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] cur_state;
	logic [STATE_W-1:0] trans_rdata;
	logic               trans_we;
	logic               trans_re;
	logic [TAW-1:0]     trans_waddr;
	logic [TAW-1:0]     trans_raddr;

	logic               valid_s1;
	logic [REQ_W-1:0]   req_s1;
	logic               first_s1;
	logic [STATE_W-1:0] addr_s1;
	logic               ematch_s1;
	logic [PAT_W-1:0]   epat_s1;

	// After a search the table output itself is the current state, so the
	// next byte can step from it in the very next cycle.
	assign cur_state = fresh_q ? (oor_q ? '0 : trans_rdata) : state_q;

	assign s_tready = (32'(q_count) + 32'(valid_s1)) < Q_DEPTH;
	assign accept   = s_tvalid & s_tready;

	assign trans_re    = accept && (s_tuser == REQ_SEARCH);
	assign trans_raddr = {cur_state[RB-1:0], fold_upper(symbol)};
	assign trans_we    = accept && (s_tuser == REQ_WR_TRANS) &&
		(32'(state_addr) < NUM_STATES);
	assign trans_waddr = {state_addr[RB-1:0], symbol};

	dfas_ram #(
		.WIDTH (STATE_W),
		.DEPTH (TDEPTH)
	) u_trans_ram (
		.clk   (clk),
		.we    (trans_we),
		.waddr (trans_waddr),
		.wdata (target_state),
		.re    (trans_re),
		.raddr (trans_raddr),
		.rdata (trans_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q  <= 1'b0;
			oor_q    <= 1'b0;
			state_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept && s_tuser == REQ_LOAD) begin
				state_q <= target_state;
				fresh_q <= 1'b0;
			end else if (accept && s_tuser == REQ_SEARCH) begin
				fresh_q <= 1'b1;
				oor_q   <= !(32'(cur_state) < NUM_STATES);
			end else begin
				state_q <= cur_state;
				fresh_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= s_tuser;
			first_s1  <= first_in_buffer;
			addr_s1   <= state_addr;
			ematch_s1 <= entry_matches;
			epat_s1   <= entry_pattern;
		end
	end

	// The state after a request is known in the cycle after it was taken.
	assign push = valid_s1;
	always_comb begin
		push_entry.is_search = (req_s1 == REQ_SEARCH);
		push_entry.is_mwrite = (req_s1 == REQ_WR_MATCH);
		push_entry.first     = first_s1;
		push_entry.state     = cur_state;
		push_entry.addr      = addr_s1;
		push_entry.ematch    = ematch_s1;
		push_entry.epat      = epat_s1;
	end

endmodule
`default_nettype wire

@@ src/dfas_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfas_queue: short queue between the front and back parts
// A small register queue that lets the stepping side and the result side
// stall independently of each other.
// ----------------------------------------------------------------------------
module dfas_queue (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	input  dfas_pkg::q_entry_t           din,
	input  wire                          pop,
	output dfas_pkg::q_entry_t           dout,
	output logic                         not_empty,
	output logic [dfas_pkg::Q_CNT_W-1:0] count
);
	import dfas_pkg::*;

	q_entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign dout      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

@@ src/dfas_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfas_back: match lookup and result formatting
// Takes requests in order from the queue, writes or reads the match table,
// keeps the buffer position and drives the result stream.
// ----------------------------------------------------------------------------
module dfas_back #(
	parameter int NUM_STATES      = dfas_pkg::NUM_STATES_DEF,
	parameter int PATTERN_ID_BITS = dfas_pkg::PAT_ID_BITS_DEF,
	parameter int MAX_BUFFER      = dfas_pkg::MAX_BUFFER_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  dfas_pkg::q_entry_t              q_dout,
	input  wire                             q_not_empty,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [dfas_pkg::OUT_DATA_W-1:0] m_tdata
);
	import dfas_pkg::*;

	localparam int ROWS = (NUM_STATES < MAX_ROWS) ? NUM_STATES : MAX_ROWS;
	localparam int RB   = $clog2(ROWS);
	localparam int PW   = (PATTERN_ID_BITS < PAT_W) ? PATTERN_ID_BITS : PAT_W;
	localparam int PB   = $clog2(MAX_BUFFER + 1);

	logic               advance;
	logic               match_we;
	logic               match_re;
	logic [PW:0]        match_rdata;
	logic [PB-1:0]      pos_q;
	logic [PB-1:0]      pos_next;

	logic               valid_s2;
	logic               search_s2;
	logic               oor_s2;
	logic [STATE_W-1:0] state_s2;
	logic [PB-1:0]      pos_s2;

	logic               out_valid_q;
	logic               found;

	assign advance = !out_valid_q || m_tready;
	assign q_pop   = q_not_empty && (!valid_s2 || advance);

	assign match_we = q_pop && q_dout.is_mwrite && (32'(q_dout.addr) < NUM_STATES);
	assign match_re = q_pop && q_dout.is_search;

	dfas_ram #(
		.WIDTH (PW + 1),
		.DEPTH (ROWS)
	) u_match_ram (
		.clk   (clk),
		.we    (match_we),
		.waddr (q_dout.addr[RB-1:0]),
		.wdata ({q_dout.ematch, q_dout.epat[PW-1:0]}),
		.re    (match_re),
		.raddr (q_dout.state[RB-1:0]),
		.rdata (match_rdata)
	);

	// The position restarts at one and saturates at the buffer limit.
	always_comb begin
		pos_next = pos_q;
		if (q_dout.first) begin
			pos_next = PB'(1);
		end else if (pos_q < PB'(MAX_BUFFER)) begin
			pos_next = pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_dout.is_search) begin
				pos_q <= pos_next;
			end
			if (q_pop) begin
				valid_s2 <= 1'b1;
			end else if (advance) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			search_s2 <= q_dout.is_search;
			oor_s2    <= !(32'(q_dout.state) < NUM_STATES);
			state_s2  <= q_dout.state;
			pos_s2    <= pos_next;
		end
	end

	assign found = search_s2 && !oor_s2 && match_rdata[PW];

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			m_tdata[0]     <= found;
			m_tdata[16:1]  <= found ? PAT_W'(match_rdata[PW-1:0]) : '0;
			m_tdata[33:17] <= found ? POS_OUT_W'(pos_s2) : '0;
			m_tdata[45:34] <= state_s2;
			m_tdata[47:46] <= '0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

@@ src/multi_pattern_dfa_search_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_pattern_dfa_search_top: Aho-Corasick DFA scanner
// Steps a loaded deterministic automaton over search bytes and reports
// matches with pattern number and position; one result per request.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while s_tready is high and gives one
// result per request, in order, from its output register. The rate is set by
// the next-state table: its registered read data is the current state and
// forms the next read address in the following cycle, so bytes step back to
// back. Match lookup, position counting and the output register sit behind a
// four-entry queue, so a stalled result stream holds off intake only once
// that queue fills. The tables are not cleared at reset; software loads the
// next-state rows and match entries it uses before searching.
module multi_pattern_dfa_search_top #(
	parameter int NUM_STATES      = dfas_pkg::NUM_STATES_DEF,
	parameter int PATTERN_ID_BITS = dfas_pkg::PAT_ID_BITS_DEF,
	parameter int MAX_BUFFER      = dfas_pkg::MAX_BUFFER_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// symbol[7:0], first_in_buffer[8], state_addr[20:9], target_state[32:21],
	// entry_matches[33], entry_pattern[49:34], zero fill [55:50]
	input  wire [dfas_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type[1:0]
	input  wire [dfas_pkg::REQ_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// match_found[0], pattern_number[16:1], match_position[33:17],
	// state_now[45:34], zero fill [47:46]
	output logic [dfas_pkg::OUT_DATA_W-1:0] m_tdata
);
	import dfas_pkg::*;

	logic               push;
	q_entry_t           push_entry;
	logic               pop;
	q_entry_t           q_dout;
	logic               q_not_empty;
	logic [Q_CNT_W-1:0] q_count;

	dfas_front #(
		.NUM_STATES (NUM_STATES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_count    (q_count),
		.push       (push),
		.push_entry (push_entry)
	);

	dfas_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_entry),
		.pop       (pop),
		.dout      (q_dout),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	dfas_back #(
		.NUM_STATES      (NUM_STATES),
		.PATTERN_ID_BITS (PATTERN_ID_BITS),
		.MAX_BUFFER      (MAX_BUFFER)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_dout      (q_dout),
		.q_not_empty (q_not_empty),
		.q_pop       (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule
`default_nettype wire
